// ===== src/olist_pkg.sv =====
// Package for the ordered list engine: request codes, status codes,
// field widths and the command word that the top level hands to every cell.
// No dependencies.
`default_nettype none

package olist_pkg;

	// Field widths of the stream words.
	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 7;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;

	// Data answered by a get whose index is out of range.
	localparam logic [DATA_W-1:0] ERR_DATA = '1;

	// Request codes carried in the slave-side tuser.
	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND     = 3'd0,
		ACT_CONTAINS   = 3'd1,
		ACT_CLEAR      = 3'd2,
		ACT_GET        = 3'd3,
		ACT_REMOVE_AT  = 3'd4,
		ACT_REMOVE_VAL = 3'd5
	} action_t;

	// Status codes returned with each result.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Command broadcast to the row of cells for one accepted request.
	typedef struct packed {
		logic              app_en;  // append that fits
		logic              rmi_en;  // remove at index that is in range
		logic              rmv_en;  // remove value request
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  pos;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/olist_cell.sv =====
// One storage cell of the list: holds one entry, loads it on append,
// takes its right neighbor's entry when a gap closes, and joins the match chain.
// Depends on olist_pkg.
`default_nettype none

module olist_cell #(
	parameter int CAPACITY = 64,
	parameter int IDX      = 0
) (
	input  wire logic                              clk,
	input  wire olist_pkg::cell_cmd_t              cmd,
	input  wire logic [$clog2(CAPACITY+1)-1:0]     count,
	input  wire logic [olist_pkg::DATA_W-1:0]      next_entry,
	input  wire logic                              hit_in,
	output logic                                   hit_out,
	output logic [olist_pkg::DATA_W-1:0]           entry,
	output logic [olist_pkg::DATA_W-1:0]           rd
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;
	localparam logic [XW-1:0] IDX_X = XW'(IDX);

	logic [olist_pkg::DATA_W-1:0] entry_q;
	logic                         valid;
	logic                         match;
	logic                         at_pos;
	logic                         write;
	logic                         shift;

	// Occupancy, value match and index decode for this cell.
	always_comb begin
		valid   = IDX_X < XW'(count);
		match   = valid && (entry_q == cmd.value);
		at_pos  = IDX_X == XW'(cmd.pos);
		hit_out = hit_in | match;
		rd      = at_pos ? entry_q : '0;
		write   = cmd.app_en && (IDX_X == XW'(count));
		shift   = (cmd.rmi_en && (IDX_X >= XW'(cmd.pos))) ||
		          (cmd.rmv_en && hit_out);
	end

	// Entry register: a new word on append, the neighbor's word when closing a gap.
	always_ff @(posedge clk) begin
		if (write) begin
			entry_q <= cmd.value;
		end else if (shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== src/ordered_list_engine_core.sv =====
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request per cycle while the result side keeps taking words;
// the row of cells compares and shifts all entries as each request is accepted.
// Reset clears the entry count and the result valid flag; the stored entries
// are not cleared and are only read below the count.
// Depends on olist_pkg and olist_cell.
`default_nettype none

module ordered_list_engine_core #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // value [31:0], position [37:32], zero pad
	input  wire logic [2:0]  s_tuser,   // action [2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // data [31:0], length [38:32], zero pad
	output logic [2:0]       m_tuser    // found [0], status [2:1]
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nxt;
	logic                         out_valid_q;
	logic [olist_pkg::DATA_W-1:0] data_q;
	logic                         found_q;
	olist_pkg::status_t           status_q;

	logic                         accept;
	olist_pkg::action_t           action;
	logic [olist_pkg::DATA_W-1:0] value;
	logic [olist_pkg::POS_W-1:0]  pos;
	logic                         full;
	logic                         pos_ok;
	logic                         found;
	logic [olist_pkg::DATA_W-1:0] rd_any;
	logic [olist_pkg::DATA_W-1:0] data_nxt;
	logic                         found_nxt;
	olist_pkg::status_t           status_nxt;
	olist_pkg::cell_cmd_t         cmd;

	logic [olist_pkg::DATA_W-1:0] cell_entry [CAPACITY];
	logic [olist_pkg::DATA_W-1:0] cell_rd    [CAPACITY];
	logic [CAPACITY:0]            hit;

	// Input unpacking and handshake.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign action   = olist_pkg::action_t'(s_tuser);
	assign value    = s_tdata[31:0];
	assign pos      = s_tdata[37:32];
	assign full     = count_q == FULL_COUNT;
	assign pos_ok   = XW'(pos) < XW'(count_q);
	assign found    = hit[CAPACITY];
	assign hit[0]   = 1'b0;

	// Row of cells; the match chain runs from index zero upward.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [olist_pkg::DATA_W-1:0] nb;
		if (i == CAPACITY - 1) begin : g_last
			assign nb = cell_entry[i];
		end else begin : g_mid
			assign nb = cell_entry[i+1];
		end
		olist_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.next_entry (nb),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.entry      (cell_entry[i]),
			.rd         (cell_rd[i])
		);
	end

	// Only the addressed cell drives a nonzero read word.
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	// Request decode: cell command, next count and the result word.
	always_comb begin
		cmd        = '0;
		cmd.value  = value;
		cmd.pos    = pos;
		count_nxt  = count_q;
		data_nxt   = '0;
		found_nxt  = 1'b0;
		status_nxt = olist_pkg::ST_OK;
		unique case (action)
			olist_pkg::ACT_APPEND: begin
				if (full) begin
					status_nxt = olist_pkg::ST_FULL;
				end else begin
					cmd.app_en = accept;
					count_nxt  = count_q + CW'(1);
				end
			end
			olist_pkg::ACT_CONTAINS: begin
				found_nxt = found;
			end
			olist_pkg::ACT_CLEAR: begin
				count_nxt = '0;
			end
			olist_pkg::ACT_GET: begin
				if (pos_ok) begin
					data_nxt = rd_any;
				end else begin
					data_nxt   = olist_pkg::ERR_DATA;
					status_nxt = olist_pkg::ST_RANGE;
				end
			end
			olist_pkg::ACT_REMOVE_AT: begin
				if (pos_ok) begin
					cmd.rmi_en = accept;
					count_nxt  = count_q - CW'(1);
				end else begin
					status_nxt = olist_pkg::ST_RANGE;
				end
			end
			olist_pkg::ACT_REMOVE_VAL: begin
				cmd.rmv_en = accept;
				found_nxt  = found;
				if (found) begin
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Control state: entry count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q   <= data_nxt;
			found_q  <= found_nxt;
			status_q <= status_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, olist_pkg::LEN_W'(count_q), data_q};
	assign m_tuser  = {status_q, found_q};

endmodule

`default_nettype wire

// ===== src/olist_checker.sv =====
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on olist_pkg and ordered_list_engine_core.
`default_nettype none

module olist_checker #(
	parameter int CAPACITY = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// A stalled result word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// Every accepted request yields a result word in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result word");

	// The reported length never exceeds the capacity.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[38:32]) <= CAPACITY)
		else $error("length beyond capacity");

	// A full status is only given when the list holds capacity entries.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:1] == olist_pkg::ST_FULL) |->
			int'(m_tdata[38:32]) == CAPACITY)
		else $error("full status with room left");

	// A match is never reported together with an error status.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == olist_pkg::ST_OK)
		else $error("found flag with error status");

endmodule

bind ordered_list_engine_core olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);

`default_nettype wire
